// ===== hdl/cllavg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cllavg_pkg
// Shared widths, register indexes, reset values and the configuration bundle
// of the current loop level averager.
// ----------------------------------------------------------------------------
package cllavg_pkg;

    localparam int GAIN_W     = 20;
    localparam int OFFSET_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int QFRAC      = 16;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int FIFO_DEPTH = 4;

    localparam int unsigned LEVEL_MAX = 65535;

    localparam logic [GAIN_W-1:0]   GAIN_RST   = 20'd74900;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd8074;
    localparam logic                WIN_EN_RST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN      = 2'd0,
        REG_OFFSET    = 2'd1,
        REG_WINDOW_EN = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain;
        logic [OFFSET_W-1:0] offset;
        logic                window_en;
    } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/current_loop_level_averager_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// current_loop_level_averager_top
// Burst-summed, scaled and window-averaged level from one 4-20 mA channel.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready with adc_sample, one sample per beat.
// Every BURST accepted samples make one result beat on out_valid / out_ready
// carrying level, instant_value and saturated; other samples give no result.
// Configuration: cfg_we writes cfg_data to the register picked by cfg_index
// (0 gain, 1 zero offset, 2 window enable) in the same cycle; index 3 is
// ignored. Write only while no burst result is pending.
// Throughput: one sample per cycle, sustained while out_ready is held high.
// The back pipeline takes one burst per cycle, so with BURST of 1 results
// stream at one per cycle too. The sum of a completed burst passes the
// queue and then the registers for multiply, scale and ring read, ring
// write, reciprocal multiply and output.
// Reset: clears the burst accumulator, queue, ring, running total and output
// register, and loads the register reset values; no clearing pass is needed.
// Receiver stall: the back pipeline holds, the four-entry queue fills, and
// in_ready drops once it is full.
// ----------------------------------------------------------------------------
module current_loop_level_averager_top
    import cllavg_pkg::*;
#(
    parameter int BURST       = 10,
    parameter int WINDOW      = 60,
    parameter int SAMPLE_BITS = 12
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] adc_sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [LEVEL_W-1:0]          level,
    output logic [LEVEL_W-1:0]          instant_value,
    output logic                        saturated,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(BURST);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             push_valid;
    logic             push_ready;
    logic [SUM_W-1:0] push_sum;
    logic             head_valid;
    logic             head_ready;
    logic [SUM_W-1:0] head_sum;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN:      cfg_next.gain      = cfg_data[GAIN_W-1:0];
                REG_OFFSET:    cfg_next.offset    = cfg_data[OFFSET_W-1:0];
                REG_WINDOW_EN: cfg_next.window_en = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain      <= GAIN_RST;
            cfg_reg.offset    <= OFFSET_RST;
            cfg_reg.window_en <= WIN_EN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cllavg_front #(
        .BURST       (BURST),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_sample (adc_sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sum   (push_sum)
    );

    cllavg_fifo #(
        .WIDTH (SUM_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_sum),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_data   (head_sum)
    );

    cllavg_back #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head_valid    (head_valid),
        .head_ready    (head_ready),
        .head_sum      (head_sum),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level         (level),
        .instant_value (instant_value),
        .saturated     (saturated)
    );

endmodule
`default_nettype wire

// ===== hdl/cllavg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cllavg_front
// Accepts raw samples, sums each burst and pushes the burst sum downstream.
// ----------------------------------------------------------------------------
module cllavg_front
    import cllavg_pkg::*;
#(
    parameter int BURST       = 10,
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_W       = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] adc_sample,
    output logic                        push_valid,
    input  wire logic                   push_ready,
    output logic [SUM_W-1:0]            push_sum
);

    localparam int CNT_W = (BURST > 1) ? $clog2(BURST) : 1;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_add;
    logic             accept;
    logic             last;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign last     = (cnt_reg == CNT_W'(BURST - 1));
    assign sum_add  = sum_reg + SUM_W'(adc_sample);

    assign push_valid = accept && last;
    assign push_sum   = sum_add;

    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (last)
            begin
                cnt_next = '0;
                sum_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cllavg_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cllavg_fifo
// Short queue of burst sums between the front and back parts.
// ----------------------------------------------------------------------------
module cllavg_fifo
    import cllavg_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] store_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");
`endif

endmodule
`default_nettype wire

// ===== hdl/cllavg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cllavg_back
// Scales burst sums; with the window enabled, updates the averaging ring and
// running total and divides by window length; result held in output register.
// ----------------------------------------------------------------------------
module cllavg_back
    import cllavg_pkg::*;
#(
    parameter int WINDOW = 60,
    parameter int SUM_W  = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              head_valid,
    output logic                   head_ready,
    input  wire logic [SUM_W-1:0]  head_sum,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [LEVEL_W-1:0]     level,
    output logic [LEVEL_W-1:0]     instant_value,
    output logic                   saturated
);

    localparam int PROD_W   = SUM_W + GAIN_W;
    localparam int SCALED_W = PROD_W - QFRAC;
    localparam int CMP_W    = ((SCALED_W > OFFSET_W) ? SCALED_W : OFFSET_W) + 1;
    localparam int PW       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LW       = $clog2(WINDOW);
    localparam int TW       = LEVEL_W + LW;
    localparam int SH       = TW + LW;
    localparam int RW       = TW + 1;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RW-1:0] RECIP = RW'(RECIP64);
    localparam logic [TW-1:0] TOTAL_MAX = TW'(WINDOW * LEVEL_MAX);

    logic                advance;

    logic                a_valid_reg;
    logic [PROD_W-1:0]   a_prod_reg;

    logic [SCALED_W-1:0] scaled;
    logic [CMP_W-1:0]    diff;
    logic [LEVEL_W-1:0]  inst;
    logic                sat;

    logic                b_valid_reg;
    logic [LEVEL_W-1:0]  b_inst_reg;
    logic                b_sat_reg;
    logic [PW-1:0]       b_addr_reg;
    logic [LEVEL_W-1:0]  b_rdata_reg;
    logic                b_rvalid_reg;
    logic                b_byp_reg;
    logic [LEVEL_W-1:0]  b_byp_data_reg;

    logic [LEVEL_W-1:0]  ring_mem [WINDOW];
    logic [WINDOW-1:0]   ring_valid_reg;
    logic [PW-1:0]       pos_reg;
    logic [PW-1:0]       pos_next;
    logic [TW-1:0]       total_reg;
    logic [TW-1:0]       total_next;
    logic [LEVEL_W-1:0]  old_entry;
    logic                ring_wr;

    logic                c_valid_reg;
    logic [LEVEL_W-1:0]  c_inst_reg;
    logic                c_sat_reg;

    logic                d_valid_reg;
    logic [LEVEL_W-1:0]  d_inst_reg;
    logic                d_sat_reg;
    logic [TW+RW-1:0]    d_prod_reg;

    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  inst_reg;
    logic                sat_reg;

    assign advance    = !out_valid_reg || out_ready;
    assign head_ready = advance;

    always_comb
    begin
        scaled = a_prod_reg[PROD_W-1:QFRAC];
        diff   = CMP_W'(scaled) - CMP_W'(cfg.offset);
        inst   = diff[LEVEL_W-1:0];
        sat    = 1'b0;
        if (diff[CMP_W-1])
        begin
            inst = '0;
        end
        else if (diff[CMP_W-2:0] > (CMP_W-1)'(LEVEL_MAX))
        begin
            inst = LEVEL_W'(LEVEL_MAX);
            sat  = 1'b1;
        end
    end

    always_comb
    begin
        pos_next   = (pos_reg == PW'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
        old_entry  = b_byp_reg ? b_byp_data_reg : (b_rvalid_reg ? b_rdata_reg : '0);
        total_next = total_reg - TW'(old_entry) + TW'(b_inst_reg);
        ring_wr    = advance && b_valid_reg && cfg.window_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            pos_reg        <= '0;
            total_reg      <= '0;
            ring_valid_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                a_valid_reg   <= head_valid;
                b_valid_reg   <= a_valid_reg;
                c_valid_reg   <= b_valid_reg;
                d_valid_reg   <= c_valid_reg;
                out_valid_reg <= d_valid_reg;
                if (a_valid_reg && cfg.window_en)
                begin
                    pos_reg <= pos_next;
                end
            end
            if (ring_wr)
            begin
                total_reg                  <= total_next;
                ring_valid_reg[b_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_prod_reg     <= PROD_W'(head_sum) * PROD_W'(cfg.gain);
            b_inst_reg     <= inst;
            b_sat_reg      <= sat;
            b_addr_reg     <= pos_reg;
            b_rdata_reg    <= ring_mem[pos_reg];
            b_rvalid_reg   <= ring_valid_reg[pos_reg];
            b_byp_reg      <= ring_wr && (b_addr_reg == pos_reg);
            b_byp_data_reg <= b_inst_reg;
            c_inst_reg     <= b_inst_reg;
            c_sat_reg      <= b_sat_reg;
            d_inst_reg     <= c_inst_reg;
            d_sat_reg      <= c_sat_reg;
            d_prod_reg     <= (TW+RW)'(total_reg) * (TW+RW)'(RECIP);
            level_reg      <= cfg.window_en ? d_prod_reg[SH +: LEVEL_W] : d_inst_reg;
            inst_reg       <= d_inst_reg;
            sat_reg        <= d_sat_reg;
        end
        if (ring_wr)
        begin
            ring_mem[b_addr_reg] <= b_inst_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign level         = level_reg;
    assign instant_value = inst_reg;
    assign saturated     = sat_reg;

`ifndef SYNTHESIS
    a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sat_reg |-> inst_reg == LEVEL_W'(LEVEL_MAX))
        else $error("saturated result without full-scale value");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pos_reg) && $stable(total_reg))
        else $error("ring moved while stalled");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOTAL_MAX)
        else $error("running total beyond window capacity");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_current_loop_level_averager_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_current_loop_level_averager_top
// Self-checking bench for the current loop level averager.
// A driver pushes converter samples from a backlog queue and a monitor takes
// result beats. Each accepted sample is folded into a local copy of the burst
// accumulator, the scaling and the window ring, and every completed burst
// queues the level, instant value and saturation flag that the monitor then
// checks. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_current_loop_level_averager_top;
    import cllavg_pkg::*;

    localparam int BURST       = 10;
    localparam int WINDOW      = 60;
    localparam int SAMPLE_BITS = 12;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
    localparam int GAIN_MAX    = (1 << GAIN_W) - 1;
    localparam int OFFSET_MAX  = (1 << OFFSET_W) - 1;
    localparam int SETTLE      = 12;
    localparam int PHASES      = 7;
    localparam int MAX_REPORTS = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] instant;
        logic               sat;
    } level_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_BITS-1:0] adc_sample    = '0;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic [LEVEL_W-1:0]     level;
    logic [LEVEL_W-1:0]     instant_value;
    logic                   saturated;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_data      = '0;

    logic [SAMPLE_BITS-1:0] adc_backlog[$];
    level_result_t          level_due[$];
    bit                     idle_en = 1'b0;
    int                     src_gap = 0;
    int                     sink_gap = 0;
    int                     err_cnt = 0;

    // local copy of the registers
    logic [GAIN_W-1:0]      gain_sh   = GAIN_RST;
    logic [OFFSET_W-1:0]    offset_sh = OFFSET_RST;
    logic                   win_sh    = WIN_EN_RST;

    // local copy of the datapath state
    int                     burst_cnt  = 0;
    logic [15:0]            burst_acc  = '0;
    logic [LEVEL_W-1:0]     ring [WINDOW];
    int                     ring_pos   = 0;
    logic [21:0]            ring_total = '0;

    current_loop_level_averager_top #(
        .BURST       (BURST),
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .adc_sample    (adc_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level         (level),
        .instant_value (instant_value),
        .saturated     (saturated),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_fault(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic fold_sample(input logic [SAMPLE_BITS-1:0] s);
        logic [63:0]   scaled;
        level_result_t r;
        burst_acc = burst_acc + 16'(s);
        burst_cnt++;
        if (burst_cnt == BURST)
        begin
            scaled    = ({48'd0, burst_acc} * {44'd0, gain_sh}) >> QFRAC;
            burst_acc = '0;
            burst_cnt = 0;
            r.sat     = 1'b0;
            if (scaled < {48'd0, offset_sh})
                r.instant = '0;
            else if (scaled - offset_sh > LEVEL_MAX)
            begin
                r.instant = LEVEL_MAX[LEVEL_W-1:0];
                r.sat     = 1'b1;
            end
            else
                r.instant = scaled[LEVEL_W-1:0] - offset_sh;
            if (win_sh)
            begin
                ring_total     = ring_total - 22'(ring[ring_pos]) + 22'(r.instant);
                ring[ring_pos] = r.instant;
                ring_pos       = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
                r.level        = LEVEL_W'(ring_total / WINDOW);
            end
            else
                r.level = r.instant;
            level_due.push_back(r);
        end
    endtask

    // driver: one beat per free slot, random gaps after a beat
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            fold_sample(adc_sample);
        if (!in_valid || in_ready)
        begin
            if (src_gap > 0)
            begin
                in_valid <= 1'b0;
                src_gap--;
            end
            else if (adc_backlog.size() != 0)
            begin
                in_valid   <= 1'b1;
                adc_sample <= adc_backlog.pop_front();
                if (idle_en && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 3);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (level_due.size() == 0)
                flag_fault($sformatf("unexpected result level %0d instant %0d sat %0d",
                                     level, instant_value, saturated));
            else if (level !== level_due[0].level
                     || instant_value !== level_due[0].instant
                     || saturated !== level_due[0].sat)
            begin
                flag_fault($sformatf({"mismatch level %0d/%0d instant %0d/%0d",
                                      " sat %0d/%0d (expected/actual)"},
                                     level_due[0].level, level,
                                     level_due[0].instant, instant_value,
                                     level_due[0].sat, saturated));
                void'(level_due.pop_front());
            end
            else
                void'(level_due.pop_front());
        end
        if (sink_gap > 0)
        begin
            out_ready <= 1'b0;
            sink_gap--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_en && $urandom_range(0, 5) == 0)
                sink_gap = $urandom_range(1, 3);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GAIN:      gain_sh   = val[GAIN_W-1:0];
            REG_OFFSET:    offset_sh = val[OFFSET_W-1:0];
            REG_WINDOW_EN: win_sh    = val[0];
            default:       ;
        endcase
    endtask

    // upper bits of the narrow registers carry junk that must be dropped
    task automatic set_config(input logic [GAIN_W-1:0] g, input logic [OFFSET_W-1:0] o,
                              input logic w);
        logic [CFG_W-1:0] v;
        write_reg(REG_GAIN, g);
        v = CFG_W'($urandom);
        v[OFFSET_W-1:0] = o;
        write_reg(REG_OFFSET, v);
        v = CFG_W'($urandom);
        v[0] = w;
        write_reg(REG_WINDOW_EN, v);
        write_reg(REG_SPARE, CFG_W'($urandom));
    endtask

    // bursts around a random center, some pinned at zero or full scale
    task automatic queue_samples(input int count);
        int k;
        int center;
        int spread;
        int v;
        center = 0;
        spread = 0;
        for (k = 0; k < count; k++)
        begin
            if (k % BURST == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       begin center = 0;          spread = 0; end
                    1:       begin center = SAMPLE_MAX; spread = 0; end
                    default: begin
                        center = $urandom_range(0, SAMPLE_MAX);
                        spread = $urandom_range(0, 400);
                    end
                endcase
            end
            v = center + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0)
                v = 0;
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            adc_backlog.push_back(v[SAMPLE_BITS-1:0]);
        end
    endtask

    // hold until every expected result is back, then let the pipeline empty
    task automatic wait_drained;
        while (adc_backlog.size() != 0 || in_valid || level_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int p;
        int k;
        for (k = 0; k < WINDOW; k++)
            ring[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_en = 1'b1;

        // reset settings: zero clamp, full scale, bit patterns
        for (k = 0; k < BURST; k++)
            adc_backlog.push_back('0);
        for (k = 0; k < BURST; k++)
            adc_backlog.push_back(SAMPLE_MAX[SAMPLE_BITS-1:0]);
        adc_backlog.push_back(12'hAAA);
        adc_backlog.push_back(12'h555);
        adc_backlog.push_back(12'h001);
        adc_backlog.push_back(12'h800);
        adc_backlog.push_back(12'h7FF);
        queue_samples(75);
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_config(GAIN_W'(GAIN_MAX), '0, 1'b0);
                1: set_config('0, OFFSET_W'(OFFSET_MAX), 1'b1);
                2: set_config(GAIN_W'(GAIN_MAX), OFFSET_W'(OFFSET_MAX), 1'b1);
                3: set_config(20'd65536, OFFSET_W'($urandom_range(0, 1000)), 1'b0);
                4: set_config(GAIN_RST, OFFSET_RST, 1'b1);
                default: set_config(GAIN_W'($urandom_range(0, GAIN_MAX)),
                                    OFFSET_W'($urandom_range(0, OFFSET_MAX)), 1'b1);
            endcase
            @(negedge clk);
            idle_en = (p % 3 != 2) && (p != PHASES - 1);
            queue_samples(110);
            wait_drained();
        end

        while (level_due.size() != 0)
        begin
            flag_fault("expected result never arrived");
            void'(level_due.pop_front());
        end
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
